FILE: hw/rtl/pres_pkg.sv
package pres_pkg;

   localparam int NumRoundKeys = 32;
   localparam int NumRounds = NumRoundKeys - 1;
   localparam int KeyIdxWidth = $clog2(NumRoundKeys);

   localparam logic [63:0] SboxFwd = 64'h21748FE3DA09B65C;
   localparam logic [63:0] SboxInv = 64'hA970364BD21C8FE5;

   localparam logic [1:0] OpLoad    = 2'd0;
   localparam logic [1:0] OpEncrypt = 2'd1;
   localparam logic [1:0] OpDecrypt = 2'd2;

   typedef logic [63:0] block_type;
   typedef block_type key_array_type [NumRoundKeys];

   // control that travels with each pipeline stage
   typedef struct packed {
      logic valid;
      logic decrypt;
   } ctl_type;

   // nibble-wise s-box layer
   function automatic block_type sub_layer(input block_type s, input logic [63:0] tbl);
      block_type r;
      logic [3:0] nib;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         nib = s[4*n +: 4];
         r[4*n +: 4] = tbl[{nib, 2'b00} +: 4];
      end
      return r;
   endfunction

   // bit i moves to i*mult mod 63, bit 63 fixed
   function automatic block_type perm_layer(input block_type s, input int mult);
      block_type r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         r[(i == 63) ? 63 : ((i * mult) % 63)] = s[i];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/pres_key_store.sv
module pres_key_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [pres_pkg::KeyIdxWidth-1:0] wr_idx,
   input  pres_pkg::block_type            wr_data,
   output pres_pkg::key_array_type        keys
);
   import pres_pkg::*;

   block_type key_ff [NumRoundKeys];

   // round key slots, read by the round stages and the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_ff[wr_idx] <= wr_data;
      end
   end

   always_comb begin
      for (int k = 0; k < NumRoundKeys; k++) begin
         keys[k] = key_ff[k];
      end
   end

endmodule

FILE: hw/rtl/pres_round.sv
module pres_round (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  pres_pkg::ctl_type   up_ctl,
   input  pres_pkg::block_type up_state,
   input  pres_pkg::block_type key_enc,
   input  pres_pkg::block_type key_dec,
   output pres_pkg::ctl_type   ctl_ff,
   output pres_pkg::block_type state_ff
);
   import pres_pkg::*;

   block_type mixed;
   block_type state_in;

   // one forward or inverse round
   always_comb begin
      if (up_ctl.decrypt) begin
         mixed = up_state ^ key_dec;
         state_in = sub_layer(perm_layer(mixed, 4), SboxInv);
      end else begin
         mixed = up_state ^ key_enc;
         state_in = perm_layer(sub_layer(mixed, SboxFwd), 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load_en) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/present_block_cipher.sv
// a cipher transfer passes through one input register, 31 round stages and
// one output register with final key
// throughput: one encrypt or decrypt per cycle unless rsp_stall holds; a
// load waits until the round pipeline has drained (keys are read per stage)
// reset clears all valid bits; round key slots are undefined until loaded
module present_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [4:0]  req_key_index,
   input  logic [63:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_block
);
   import pres_pkg::*;

   key_array_type keys;
   ctl_type       ctl_q [NumRoundKeys];
   block_type     state_q [NumRoundKeys];
   logic          rdy [NumRoundKeys+1];
   logic          busy;
   logic          is_load;
   logic          is_cipher;
   logic          take;
   ctl_type       in_ctl;
   ctl_type       ctl0_ff;
   block_type     state0_ff;
   logic          out_valid_ff;
   block_type     out_ff;
   block_type     out_in;

   assign is_load   = req_operation == OpLoad;
   assign is_cipher = req_operation == OpEncrypt || req_operation == OpDecrypt;

   // ready chain: a stage takes when empty or when it moves on
   always_comb begin
      rdy[NumRoundKeys] = !out_valid_ff || !rsp_stall;
      for (int j = NumRoundKeys - 1; j >= 0; j--) begin
         rdy[j] = !ctl_q[j].valid || rdy[j+1];
      end
      busy = 1'b0;
      for (int j = 0; j < NumRoundKeys; j++) begin
         busy = busy | ctl_q[j].valid;
      end
   end

   // loads wait for in-flight blocks to finish with the old keys
   assign req_stall = is_load ? busy : !rdy[0];
   assign take      = req_valid && !req_stall;

   pres_key_store u_keys (
      .clock   (clock),
      .wr_en   (take && is_load),
      .wr_idx  (req_key_index),
      .wr_data (req_data_word),
      .keys    (keys)
   );

   assign in_ctl.valid   = take && is_cipher;
   assign in_ctl.decrypt = req_operation == OpDecrypt;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (rdy[0]) begin
         ctl0_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         state0_ff <= req_data_word;
      end
   end

   assign ctl_q[0]   = ctl0_ff;
   assign state_q[0] = state0_ff;

   // round stages
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      pres_round u_round (
         .clock    (clock),
         .reset    (reset),
         .load_en  (rdy[g+1]),
         .up_ctl   (ctl_q[g]),
         .up_state (state_q[g]),
         .key_enc  (keys[g]),
         .key_dec  (keys[NumRoundKeys-1-g]),
         .ctl_ff   (ctl_q[g+1]),
         .state_ff (state_q[g+1])
      );
   end

   // output register with final key whitening
   assign out_in = state_q[NumRounds] ^
                   (ctl_q[NumRounds].decrypt ? keys[0] : keys[NumRoundKeys-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rdy[NumRoundKeys]) begin
         out_valid_ff <= ctl_q[NumRounds].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NumRoundKeys]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_block = out_ff;

endmodule

FILE: hw/rtl/pres_checker.sv
module pres_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_block
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty pipeline takes any item after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // stalled result stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");

   // stalled result data holds
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result_block))
      else $error("result changed under stall");

endmodule

bind present_block_cipher pres_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_block (rsp_result_block)
);

FILE: bench/present_block_cipher_tb.sv
module present_block_cipher_tb;
   import pres_pkg::*;

   localparam int ResultLatency = 32;
   localparam int WatchdogLimit = 20000;
   localparam int RandomItems   = 540;
   localparam logic [1:0] OpUnused = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [4:0]  req_key_index;
   logic [63:0] req_data_word;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_result_block;

   // one row of the directed table
   typedef struct {
      logic [1:0]  op;
      logic [4:0]  idx;
      logic [63:0] data;
      logic        has_expect;
      logic [63:0] expect_block;
   } stim_row_type;

   logic [63:0]  round_keys [NumRoundKeys];
   logic [63:0]  expected_blocks [$];
   int           error_count;
   int           idle_cycles;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           hold_off;
   bit           timed_out;
   stim_row_type directed_rows [$];

   present_block_cipher i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_key_index    (req_key_index),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_block (rsp_result_block)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // nibble substitution through a packed 16-entry table
   function automatic logic [63:0] substitute(input logic [63:0] s, input logic [63:0] tbl);
      logic [63:0] r;
      logic [3:0]  nib;
      r = '0;
      for (int n = 0; n < 16; n++) begin
         nib = s[4*n +: 4];
         r[4*n +: 4] = tbl[4*nib +: 4];
      end
      return r;
   endfunction

   // bit shuffle; multiplier 16 forward, 4 inverse
   function automatic logic [63:0] shuffle_bits(input logic [63:0] s, input int mult);
      logic [63:0] r;
      int          dst;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         dst = (i == 63) ? 63 : (i * mult) % 63;
         r[dst] = s[i];
      end
      return r;
   endfunction

   // expected cipher output from the mirrored key slots
   function automatic logic [63:0] cipher_block(input logic [1:0] op, input logic [63:0] blk);
      logic [63:0] s;
      s = blk;
      if (op == OpEncrypt) begin
         for (int r = 0; r < NumRoundKeys - 1; r++) begin
            s = shuffle_bits(substitute(s ^ round_keys[r], SboxFwd), 16);
         end
         s = s ^ round_keys[NumRoundKeys - 1];
      end else begin
         for (int r = NumRoundKeys - 1; r > 0; r--) begin
            s = substitute(shuffle_bits(s ^ round_keys[r], 4), SboxInv);
         end
         s = s ^ round_keys[0];
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // one transfer on the request side, with the sender's own idle gaps
   task automatic send_item(input logic [1:0] op, input logic [4:0] idx,
                            input logic [63:0] data, input bit has_exp,
                            input logic [63:0] exp_blk);
      logic [63:0] predicted;
      while (!hold_off && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key_index <= idx;
      req_data_word <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      if (op == OpLoad) begin
         round_keys[idx] = data;
      end else if (op == OpEncrypt || op == OpDecrypt) begin
         predicted = cipher_block(op, data);
         if (has_exp && predicted !== exp_blk)
            report_mismatch("table row", predicted, exp_blk);
         expected_blocks.push_back(has_exp ? exp_blk : predicted);
      end
   endtask

   task automatic wait_drained();
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (ResultLatency + 4) @(posedge clock);
   endtask

   task automatic load_all_keys(input bit random_keys, input logic [63:0] fixed);
      for (int k = 0; k < NumRoundKeys; k++) begin
         send_item(OpLoad, k[4:0], random_keys ? {$urandom, $urandom} : fixed, 0, '0);
      end
   endtask

   // receiver stall and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected result", rsp_result_block, '0);
            end else begin
               if (rsp_result_block !== expected_blocks[0])
                  report_mismatch("result_block", rsp_result_block, expected_blocks[0]);
               void'(expected_blocks.pop_front());
            end
         end
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired at %0t", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // long receiver hold-off while the sender keeps pushing
   task automatic hold_receiver(input int cycles);
      hold_off = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off = 1'b0;
   endtask

   task automatic random_phase(input int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_item(OpLoad, 5'($urandom_range(31)), {$urandom, $urandom}, 0, '0);
         else if (pick < 11)
            send_item(OpUnused, 5'($urandom), {$urandom, $urandom}, 0, '0);
         else
            send_item(pick < 55 ? OpEncrypt : OpDecrypt, 5'($urandom),
                      {$urandom, $urandom}, 0, '0);
      end
   endtask

   initial begin
      logic [63:0] blk;
      error_count   = 0;
      hold_off      = 1'b0;
      timed_out     = 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 50;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OpLoad;
      req_key_index = '0;
      req_data_word = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all keys zero, then all ones; extremes of the block
      directed_rows.push_back('{OpEncrypt, 5'd0,  64'h0, 1'b0, 64'h0});
      directed_rows.push_back('{OpEncrypt, 5'd31, '1,    1'b0, 64'h0});
      directed_rows.push_back('{OpDecrypt, 5'd17, 64'h0, 1'b0, 64'h0});
      directed_rows.push_back('{OpDecrypt, 5'd0,  '1,    1'b0, 64'h0});
      directed_rows.push_back('{OpUnused,  5'd31, '1,    1'b0, 64'h0});
      directed_rows.push_back('{OpEncrypt, 5'd5,  64'h0123456789ABCDEF, 1'b0, 64'h0});
      directed_rows.push_back('{OpDecrypt, 5'd5,  64'h8000000000000001, 1'b0, 64'h0});
      load_all_keys(0, 64'h0);
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
                   directed_rows[i].has_expect, directed_rows[i].expect_block);
      load_all_keys(0, '1);
      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].data,
                   directed_rows[i].has_expect, directed_rows[i].expect_block);
      // encrypt then decrypt round trip with random keys
      load_all_keys(1, '0);
      blk = {$urandom, $urandom};
      send_item(OpEncrypt, 5'd0, blk, 0, '0);
      send_item(OpDecrypt, 5'd0, cipher_block(OpEncrypt, blk), 1'b1, blk);

      // random with idling patterns
      random_phase(RandomItems / 3);
      // only cipher transfers here so the pipeline fills up
      fork
         hold_receiver(400);
         for (int n = 0; n < 60; n++)
            send_item(OpEncrypt, 5'd0, {$urandom, $urandom}, 0, '0);
      join
      send_idle_pct = 50;
      recv_idle_pct = 14;
      random_phase(RandomItems / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(RandomItems / 3);
      req_valid <= 1'b0;

      wait_drained();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/pres_pkg.sv
hw/rtl/pres_key_store.sv
hw/rtl/pres_round.sv
hw/rtl/present_block_cipher.sv
hw/rtl/pres_checker.sv
bench/present_block_cipher_tb.sv
